// ----- rtl/core/clm_pkg.sv -----
package clm_pkg;

    // Per-lock mode as kept in the lock table
    typedef enum logic [1:0] {
        MODE_FREE      = 2'd0,
        MODE_LOCKED    = 2'd1,
        MODE_EXPECTING = 2'd2
    } lock_mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RETRY = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    // Outgoing message kinds
    typedef enum logic [1:0] {
        MSG_NONE   = 2'd0,
        MSG_REVOKE = 2'd1,
        MSG_RETRY  = 2'd2
    } msg_kind_t;

    // Controller states
    typedef enum logic [1:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_LOOKUP,
        CS_DECIDE
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic lookup;
        logic decide;
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- rtl/core/clm_ctrl.sv -----
module clm_ctrl
    import clm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t dp_status,
    output ctl_cmd_t   cmd,
    output logic       in_ready
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through clear, idle, lookup and decide
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_CLEAR:
            begin
                if (dp_status.clear_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_LOOKUP;
                end
            end
            CS_LOOKUP:
            begin
                state_next = CS_DECIDE;
            end
            CS_DECIDE:
            begin
                if (!dp_status.out_busy)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_CLEAR;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            CS_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            CS_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            CS_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            CS_DECIDE:
            begin
                cmd.decide = !dp_status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/clm_datapath.sv -----
module clm_datapath
    import clm_pkg::*;
#(
    parameter int NUM_LOCKS   = 16,
    parameter int NUM_CLIENTS = 8,
    parameter int QUEUE_DEPTH = 8,
    localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
    localparam int CLI_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    output dp_status_t        dp_status,
    input  logic              operation,
    input  logic [LOCK_W-1:0] lock_index,
    input  logic [CLI_W-1:0]  client_number,
    output logic [1:0]        status,
    output logic [1:0]        message_kind,
    output logic [CLI_W-1:0]  message_client,
    output logic [LOCK_W-1:0] message_lock,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = 2 + CLI_W + 1 + HEAD_W + CNT_W;
    localparam int WAIT_DEPTH = NUM_LOCKS * QUEUE_DEPTH;
    localparam int WADDR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam logic [WADDR_W-1:0] QD_ADDR = WADDR_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0] QD_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] QD_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(QUEUE_DEPTH - 1);

    // Lock table and per-lock wait queues
    logic [ENT_W-1:0] lock_mem [NUM_LOCKS];
    logic [CLI_W-1:0] wait_mem [WAIT_DEPTH];

    logic [LOCK_W-1:0] clr_cnt_reg;
    logic              req_op_reg;
    logic [LOCK_W-1:0] req_lock_reg;
    logic [CLI_W-1:0]  req_client_reg;
    logic [ENT_W-1:0]  lock_rd_reg;
    logic [CLI_W-1:0]  wait_rd_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [1:0]        kind_reg;
    logic [CLI_W-1:0]  dest_reg;
    logic [LOCK_W-1:0] msg_lock_reg;

    // Fields of the entry read for this request
    logic [1:0]        ent_mode;
    logic [CLI_W-1:0]  ent_holder;
    logic              ent_revoke;
    logic [HEAD_W-1:0] ent_head;
    logic [CNT_W-1:0]  ent_count;

    // Decision results
    logic [1:0]        new_mode;
    logic [CLI_W-1:0]  new_holder;
    logic              new_revoke;
    logic [HEAD_W-1:0] new_head;
    logic [CNT_W-1:0]  new_count;
    logic              wr_lock;
    logic              wr_wait;
    status_t           dec_status;
    msg_kind_t         dec_kind;
    logic [CLI_W-1:0]  dec_dest;

    logic              req_ok;
    logic              queue_full;
    logic [CNT_W:0]    tail_sum;
    logic [HEAD_W-1:0] tail_slot;
    logic [HEAD_W-1:0] head_inc;
    logic [WADDR_W-1:0] wait_rd_addr;
    logic [WADDR_W-1:0] wait_wr_addr;
    logic [LOCK_W-1:0] lock_wr_addr;
    logic [ENT_W-1:0]  lock_wr_data;

    assign ent_count  = lock_rd_reg[CNT_W-1:0];
    assign ent_head   = lock_rd_reg[CNT_W +: HEAD_W];
    assign ent_revoke = lock_rd_reg[CNT_W + HEAD_W];
    assign ent_holder = lock_rd_reg[CNT_W + HEAD_W + 1 +: CLI_W];
    assign ent_mode   = lock_rd_reg[ENT_W-1 -: 2];

    // Sweep the lock table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign dp_status.clear_last = (clr_cnt_reg == LOCK_W'(NUM_LOCKS - 1));
    assign dp_status.out_busy   = out_valid_reg && !out_ready;

    // Capture the request beat and read its lock entry
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg     <= operation;
            req_lock_reg   <= lock_index;
            req_client_reg <= client_number;
            lock_rd_reg    <= lock_mem[lock_index];
        end
    end

    // Queue slot arithmetic
    assign tail_sum  = (CNT_W + 1)'(ent_head) + (CNT_W + 1)'(ent_count);
    assign tail_slot = (tail_sum >= QD_SUM) ? HEAD_W'(tail_sum - QD_SUM) : HEAD_W'(tail_sum);
    assign head_inc  = (ent_head == HEAD_LAST) ? '0 : ent_head + 1'b1;
    assign wait_rd_addr = WADDR_W'(req_lock_reg) * QD_ADDR + WADDR_W'(ent_head);
    assign wait_wr_addr = WADDR_W'(req_lock_reg) * QD_ADDR + WADDR_W'(tail_slot);

    // Read the queue head slot, write an enqueued client
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            wait_rd_reg <= wait_mem[wait_rd_addr];
        end
        if (cmd.decide && wr_wait)
        begin
            wait_mem[wait_wr_addr] <= req_client_reg;
        end
    end

    assign req_ok = ({1'b0, req_lock_reg} < (LOCK_W + 1)'(NUM_LOCKS))
                 && ({1'b0, req_client_reg} < (CLI_W + 1)'(NUM_CLIENTS));
    assign queue_full = (ent_count >= QD_CNT);

    // Decide the lock transition for this request
    always_comb
    begin
        new_mode   = ent_mode;
        new_holder = ent_holder;
        new_revoke = ent_revoke;
        new_head   = ent_head;
        new_count  = ent_count;
        wr_lock    = 1'b0;
        wr_wait    = 1'b0;
        dec_status = STATUS_ERROR;
        dec_kind   = MSG_NONE;
        dec_dest   = '0;
        if (req_ok)
        begin
            if (!req_op_reg)
            begin
                unique case (ent_mode)
                    MODE_FREE:
                    begin
                        new_mode   = MODE_LOCKED;
                        new_holder = req_client_reg;
                        new_revoke = 1'b0;
                        wr_lock    = 1'b1;
                        dec_status = STATUS_OK;
                    end
                    MODE_EXPECTING:
                    begin
                        if (ent_holder == req_client_reg)
                        begin
                            new_mode   = MODE_LOCKED;
                            wr_lock    = 1'b1;
                            dec_status = STATUS_OK;
                            if (ent_revoke)
                            begin
                                dec_kind = MSG_REVOKE;
                                dec_dest = ent_holder;
                            end
                        end
                        else if (!queue_full)
                        begin
                            new_count  = ent_count + 1'b1;
                            new_revoke = 1'b1;
                            wr_lock    = 1'b1;
                            wr_wait    = 1'b1;
                            dec_status = STATUS_RETRY;
                        end
                    end
                    MODE_LOCKED:
                    begin
                        if (ent_holder != req_client_reg && !queue_full)
                        begin
                            new_count  = ent_count + 1'b1;
                            wr_lock    = 1'b1;
                            wr_wait    = 1'b1;
                            dec_status = STATUS_RETRY;
                            if (!ent_revoke)
                            begin
                                new_revoke = 1'b1;
                                dec_kind   = MSG_REVOKE;
                                dec_dest   = ent_holder;
                            end
                        end
                    end
                    default:
                    begin
                        dec_status = STATUS_ERROR;
                    end
                endcase
            end
            else if (ent_mode == MODE_LOCKED && ent_holder == req_client_reg)
            begin
                wr_lock    = 1'b1;
                dec_status = STATUS_OK;
                if (ent_count == '0)
                begin
                    new_mode   = MODE_FREE;
                    new_holder = '0;
                    new_revoke = 1'b0;
                end
                else
                begin
                    new_mode   = MODE_EXPECTING;
                    new_holder = wait_rd_reg;
                    new_head   = head_inc;
                    new_count  = ent_count - 1'b1;
                    new_revoke = (ent_count != CNT_W'(1));
                    dec_kind   = MSG_RETRY;
                    dec_dest   = wait_rd_reg;
                end
            end
        end
    end

    // Write back the entry, or the reset entry while clearing
    assign lock_wr_addr = cmd.clear ? clr_cnt_reg : req_lock_reg;
    assign lock_wr_data = cmd.clear ? '0
                        : {new_mode, new_holder, new_revoke, new_head, new_count};

    always_ff @(posedge clk)
    begin
        if (cmd.clear || (cmd.decide && wr_lock))
        begin
            lock_mem[lock_wr_addr] <= lock_wr_data;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            status_reg   <= dec_status;
            kind_reg     <= dec_kind;
            dest_reg     <= (dec_kind != MSG_NONE) ? dec_dest : '0;
            msg_lock_reg <= (dec_kind != MSG_NONE) ? req_lock_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign message_kind   = kind_reg;
    assign message_client = dest_reg;
    assign message_lock   = msg_lock_reg;

endmodule

// ----- rtl/core/caching_lock_manager_top.sv -----
// Lock table manager with per-lock wait queues.
// Each request reads its lock entry as it is taken, then its queue head, then
// is decided and written back, all through single-port table memories; a
// waiting result beat stalls the decide step. No new request is taken until
// the last is decided. Reset: asynchronous, active low; a clearing pass then
// frees every lock, and no request is taken until it ends.
module caching_lock_manager_top
    import clm_pkg::*;
#(
    parameter int NUM_LOCKS   = 16,
    parameter int NUM_CLIENTS = 8,
    parameter int QUEUE_DEPTH = 8,
    localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
    localparam int CLI_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [LOCK_W-1:0] lock_index,
    input  logic [CLI_W-1:0]  client_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [1:0]        message_kind,
    output logic [CLI_W-1:0]  message_client,
    output logic [LOCK_W-1:0] message_lock
);

    ctl_cmd_t   cmd;
    dp_status_t dp_status;

    // Sequence each request
    clm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .dp_status (dp_status),
        .cmd       (cmd),
        .in_ready  (in_ready)
    );

    // Lock table, queues and result register
    clm_datapath #(
        .NUM_LOCKS   (NUM_LOCKS),
        .NUM_CLIENTS (NUM_CLIENTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .operation      (operation),
        .lock_index     (lock_index),
        .client_number  (client_number),
        .status         (status),
        .message_kind   (message_kind),
        .message_client (message_client),
        .message_lock   (message_lock),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    // One request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

    // Hold a waiting result beat unchanged until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready)
            |=> (out_valid && $stable(status) && $stable(message_kind)
                 && $stable(message_client) && $stable(message_lock)))
    else $error("result beat dropped or changed while waiting");

    // Errors never carry a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_ERROR) |-> (message_kind == MSG_NONE))
    else $error("error result carries a message");

    // Message fields are zero when no message goes out
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_kind == MSG_NONE)
            |-> (message_client == '0 && message_lock == '0))
    else $error("message fields set without a message");

endmodule
